[hw/rtl/nos_pkg.sv]
`timescale 1ns / 1ps
package nos_pkg;
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int SqWidth   = 32;
    // scaled values: products up to 64+64 bits, numerator sums need a few more
    localparam int AccWidth  = 136;
    localparam int CfgIdxW   = 2;
    // shared multiplier operand width: one data word plus a sign bit
    localparam int MulWidth  = DataWidth + 1;

    localparam logic [CfgIdxW-1:0] CfgStepSq      = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgStartFirst  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgStartSecond = 2'd2;

    localparam int QuoWidth  = DataWidth + 2;
    localparam int CntWidth  = 6;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_m_den,
        t_st_m_s,
        t_st_m_s0,
        t_st_m_sm,
        t_st_m_g0,
        t_st_m_g0_lo,
        t_st_m_g0_hi,
        t_st_m_gm,
        t_st_m_gm_lo,
        t_st_m_gm_hi,
        t_st_setup,
        t_st_div,
        t_st_round,
        t_st_out
    } t_state;

    typedef struct packed {
        logic start;
        logic [AccWidth-1:0] num_abs;
        logic [AccWidth-1:0] den_abs;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [QuoWidth-1:0] quo;
        logic                ovf;
    } t_div_rsp;
endpackage

[hw/rtl/numerov_ode_stepper_unit.sv]
`timescale 1ns / 1ps
// Numerov stepper: one grid point per input word (tdata = g_sample, s_sample;
// tlast = last); one result word per input word (tdata = y_value, tlast = copy of
// last, tuser = saturated, zero_divisor). The first two words of a sweep go straight
// to the output state and return the start registers. Later words pass ten times
// through one shared 33x33 multiplier, then a setup state, a divider that yields
// one of 34 quotient bits per cycle, a rounding state and the output state. A zero
// divisor skips the divider and the rounding state and returns zero. One word is in
// flight at a time: the next word is taken only once the sequencer is back in idle;
// a result still waiting in the output register holds the sequencer in its output
// state until the result is taken.
module numerov_ode_stepper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // g_sample[31:0], s_sample[63:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // y_value[31:0]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // saturated[0], zero_divisor[1]
);
    localparam int DW = nos_pkg::DataWidth;
    localparam int AW = nos_pkg::AccWidth;
    localparam int F  = nos_pkg::FracBits;
    localparam int MW = nos_pkg::MulWidth;
    localparam int PW = 2 * MW;

    logic [nos_pkg::SqWidth-1:0] r_step_sq;
    logic [DW-1:0]       r_start_first, r_start_second;
    logic [DW-1:0]       r_g_hist [2];
    logic [DW-1:0]       r_s_hist [2];
    logic [DW-1:0]       r_y_hist [2];
    logic [1:0]          r_seen;
    logic [DW-1:0]       r_g, r_s;
    logic                r_last;
    nos_pkg::t_state     r_state, n_state;
    logic signed [AW-1:0] r_den, r_num;
    logic signed [PW-1:0] r_hg;
    logic                r_neg;
    logic [DW-1:0]       r_y;
    logic                r_sat, r_zd;
    logic                r_ovalid;
    logic [DW-1:0]       r_oy;
    logic                r_olast, r_osat, r_ozd;
    nos_pkg::t_div_req   w_req;
    nos_pkg::t_div_rsp   w_rsp;

    logic signed [AW-1:0] w_k;
    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_mul;
    logic signed [AW-1:0] w_mulx, w_mul10, w_y0x, w_ymx;
    logic                 w_accept;
    logic                 w_out_free;
    logic signed [DW:0]   w_lim;

    assign w_k = AW'(12) <<< (28 + F);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == nos_pkg::t_st_idle);
    assign w_out_free = !r_ovalid || m_axis_tready;

    // shared multiplier operand select
    always_comb begin
        w_ma = MW'(r_step_sq);
        w_mb = '0;
        case (r_state)
            nos_pkg::t_st_m_den: w_mb = MW'($signed(r_g));
            nos_pkg::t_st_m_s:   w_mb = MW'($signed(r_s));
            nos_pkg::t_st_m_s0:  w_mb = MW'($signed(r_s_hist[1]));
            nos_pkg::t_st_m_sm:  w_mb = MW'($signed(r_s_hist[0]));
            nos_pkg::t_st_m_g0:  w_mb = MW'($signed(r_g_hist[1]));
            nos_pkg::t_st_m_g0_lo: begin
                w_ma = MW'(r_hg[DW-1:0]);
                w_mb = MW'($signed(r_y_hist[1]));
            end
            nos_pkg::t_st_m_g0_hi: begin
                w_ma = MW'($signed(r_hg[2*DW-1:DW]));
                w_mb = MW'($signed(r_y_hist[1]));
            end
            nos_pkg::t_st_m_gm:  w_mb = MW'($signed(r_g_hist[0]));
            nos_pkg::t_st_m_gm_lo: begin
                w_ma = MW'(r_hg[DW-1:0]);
                w_mb = MW'($signed(r_y_hist[0]));
            end
            nos_pkg::t_st_m_gm_hi: begin
                w_ma = MW'($signed(r_hg[2*DW-1:DW]));
                w_mb = MW'($signed(r_y_hist[0]));
            end
            default: ;
        endcase
    end
    assign w_mul   = w_ma * w_mb;
    assign w_mulx  = AW'(w_mul);
    assign w_mul10 = (w_mulx <<< 3) + (w_mulx <<< 1);
    assign w_y0x   = AW'($signed(r_y_hist[1]));
    assign w_ymx   = AW'($signed(r_y_hist[0]));

    always_comb begin
        n_state = r_state;
        case (r_state)
            nos_pkg::t_st_idle:    if (w_accept) n_state = (r_seen == 2'd2) ?
                                       nos_pkg::t_st_m_den : nos_pkg::t_st_out;
            nos_pkg::t_st_m_den:   n_state = nos_pkg::t_st_m_s;
            nos_pkg::t_st_m_s:     n_state = nos_pkg::t_st_m_s0;
            nos_pkg::t_st_m_s0:    n_state = nos_pkg::t_st_m_sm;
            nos_pkg::t_st_m_sm:    n_state = nos_pkg::t_st_m_g0;
            nos_pkg::t_st_m_g0:    n_state = nos_pkg::t_st_m_g0_lo;
            nos_pkg::t_st_m_g0_lo: n_state = nos_pkg::t_st_m_g0_hi;
            nos_pkg::t_st_m_g0_hi: n_state = nos_pkg::t_st_m_gm;
            nos_pkg::t_st_m_gm:    n_state = nos_pkg::t_st_m_gm_lo;
            nos_pkg::t_st_m_gm_lo: n_state = nos_pkg::t_st_m_gm_hi;
            nos_pkg::t_st_m_gm_hi: n_state = nos_pkg::t_st_setup;
            nos_pkg::t_st_setup:   n_state = (r_den == '0) ? nos_pkg::t_st_out
                                                           : nos_pkg::t_st_div;
            nos_pkg::t_st_div:     if (w_rsp.done) n_state = nos_pkg::t_st_round;
            nos_pkg::t_st_round:   n_state = nos_pkg::t_st_out;
            nos_pkg::t_st_out:     if (w_out_free) n_state = nos_pkg::t_st_idle;
            default:               n_state = nos_pkg::t_st_idle;
        endcase
    end

    always_comb begin
        w_req.start   = (r_state == nos_pkg::t_st_setup) && (r_den != '0);
        w_req.num_abs = r_num[AW-1] ? -r_num : r_num;
        w_req.den_abs = r_den[AW-1] ? -r_den : r_den;
    end

    nos_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_lim = $signed({1'b0, 1'b1, {(DW-1){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= nos_pkg::t_st_idle;
            r_step_sq      <= '0;
            r_start_first  <= '0;
            r_start_second <= '0;
            r_seen         <= '0;
            r_g_hist       <= '{default: '0};
            r_s_hist       <= '{default: '0};
            r_y_hist       <= '{default: '0};
            r_ovalid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nos_pkg::CfgStepSq:      r_step_sq      <= i_cfg_data;
                    nos_pkg::CfgStartFirst:  r_start_first  <= i_cfg_data;
                    nos_pkg::CfgStartSecond: r_start_second <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == nos_pkg::t_st_out && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_accept) begin
                r_g    <= s_axis_tdata[31:0];
                r_s    <= s_axis_tdata[63:32];
                r_last <= s_axis_tlast;
                r_sat  <= 1'b0;
                r_zd   <= 1'b0;
                r_y    <= (r_seen == 2'd0) ? r_start_first : r_start_second;
            end
            case (r_state)
                nos_pkg::t_st_m_den:   r_den <= w_k + w_mulx;
                nos_pkg::t_st_m_s:     r_num <= w_mulx <<< F;
                nos_pkg::t_st_m_s0:    r_num <= r_num + (w_mul10 <<< F);
                nos_pkg::t_st_m_sm:    r_num <= r_num + (w_mulx <<< F);
                nos_pkg::t_st_m_g0: begin
                    r_hg  <= w_mul;
                    r_num <= r_num + (((w_y0x <<< 4) + (w_y0x <<< 3)) <<< (28 + F));
                end
                nos_pkg::t_st_m_g0_lo: r_num <= r_num - w_mul10;
                nos_pkg::t_st_m_g0_hi: r_num <= r_num - (w_mul10 <<< DW);
                nos_pkg::t_st_m_gm: begin
                    r_hg  <= w_mul;
                    r_num <= r_num - (((w_ymx <<< 3) + (w_ymx <<< 2)) <<< (28 + F));
                end
                nos_pkg::t_st_m_gm_lo: r_num <= r_num - w_mulx;
                nos_pkg::t_st_m_gm_hi: r_num <= r_num - (w_mulx <<< DW);
                nos_pkg::t_st_setup: begin
                    r_neg <= r_num[AW-1] ^ r_den[AW-1];
                    if (r_den == '0) begin
                        r_zd <= 1'b1;
                        r_y  <= '0;
                    end
                end
                nos_pkg::t_st_round: begin
                    if (w_rsp.ovf || (!r_neg && $signed({1'b0, w_rsp.quo}) >= w_lim)) begin
                        r_sat <= 1'b1;
                        r_y   <= r_neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                    end else if (r_neg && $signed({1'b0, w_rsp.quo}) > w_lim) begin
                        r_sat <= 1'b1;
                        r_y   <= {1'b1, {(DW-1){1'b0}}};
                    end else begin
                        r_y <= r_neg ? DW'(-w_rsp.quo) : w_rsp.quo[DW-1:0];
                    end
                end
                nos_pkg::t_st_out: begin
                    if (w_out_free) begin
                        r_oy    <= r_y;
                        r_olast <= r_last;
                        r_osat  <= r_sat;
                        r_ozd   <= r_zd;
                        if (r_last) begin
                            r_g_hist <= '{default: '0};
                            r_s_hist <= '{default: '0};
                            r_y_hist <= '{default: '0};
                            r_seen   <= '0;
                        end else begin
                            r_g_hist <= '{r_g_hist[1], r_g};
                            r_s_hist <= '{r_s_hist[1], r_s};
                            r_y_hist <= '{r_y_hist[1], r_y};
                            if (r_seen != 2'd2) r_seen <= r_seen + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oy;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_ozd, r_osat};
endmodule

[hw/rtl/nos_divider.sv]
`timescale 1ns / 1ps
module nos_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nos_pkg::t_div_req i_req,
    output nos_pkg::t_div_rsp o_rsp
);
    localparam int AW = nos_pkg::AccWidth;
    localparam int QW = nos_pkg::QuoWidth;
    localparam int CW = nos_pkg::CntWidth;
    // restoring division producing QW quotient bits; higher quotient bits mean overflow
    logic [AW-1:0] r_rem;
    logic [AW-1:0] r_num;
    logic [AW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic          r_ovf;
    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [AW:0]   w_trial;
    logic [AW:0]   w_sh;

    assign w_sh    = {r_rem, r_num[AW-1]};
    assign w_trial = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // prefix: check num < den * 2^QW, else quotient overflows
            r_ovf <= (i_req.num_abs >> QW) >= i_req.den_abs;
            r_rem <= i_req.num_abs >> QW;
            r_num <= i_req.num_abs << (AW - QW);
            r_den <= i_req.den_abs;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            if (!w_trial[AW]) begin
                r_rem <= w_trial[AW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[AW-1:0];
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    // rounding folded in here: the quotient gets one added when 2*rem >= den
    logic w_half;
    assign w_half = ({r_rem, 1'b0} >= {1'b0, r_den});

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        o_rsp.quo  = r_quo + QW'(w_half);
        o_rsp.ovf  = r_ovf | (&r_quo & w_half);
    end
endmodule

[sim/numerov_checker.sv]
`timescale 1ns / 1ps
module numerov_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_last,
    input  logic [1:0]  i_out_user,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [31:0] y;
        logic        last;
        logic        sat;
        logic        zdiv;
    } t_point;

    t_point     y_queue[$];
    logic [31:0] h2, y_first, y_second;
    logic signed [31:0] g_hist[2], s_hist[2], y_hist[2];
    int          seen;

    assign o_pending = y_queue.size();

    function automatic t_point numerov_solve(input logic signed [31:0] gp,
                                             input logic signed [31:0] sp,
                                             input logic last);
        logic signed [255:0] h, k, den, num, ssum, c0, cm, na, da, q, r, lim;
        t_point p;
        logic neg;
        h    = $signed({224'd0, h2});
        k    = 256'sd12 <<< (28 + nos_pkg::FracBits);
        p    = '0;
        p.last = last;
        den  = k + h * gp;
        if (den == 0) begin
            p.zdiv = 1'b1;
            return p;
        end
        ssum = 256'(gp) * 0 + sp + 10 * 256'(s_hist[1]) + s_hist[0];
        num  = (h * ssum) <<< nos_pkg::FracBits;
        c0   = k - 5 * (h * g_hist[1]);
        num  = num + 2 * c0 * y_hist[1];
        cm   = k + h * g_hist[0];
        num  = num - cm * y_hist[0];
        neg  = (num < 0) != (den < 0);
        na   = (num < 0) ? -num : num;
        da   = (den < 0) ? -den : den;
        q    = na / da;
        r    = na - q * da;
        if ((r <<< 1) >= da) q = q + 1;
        lim  = 256'sd1 <<< 31;
        if (!neg && q >= lim) begin
            p.sat = 1'b1;
            p.y   = 32'h7fff_ffff;
        end else if (neg && q > lim) begin
            p.sat = 1'b1;
            p.y   = 32'h8000_0000;
        end else begin
            p.y = neg ? -q[31:0] : q[31:0];
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point p, e;
        if (!i_rst_n) begin
            h2 <= '0;
            y_first <= '0;
            y_second <= '0;
            g_hist <= '{0, 0};
            s_hist <= '{0, 0};
            y_hist <= '{0, 0};
            seen <= 0;
            o_errors <= 0;
            y_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nos_pkg::CfgStepSq:      h2 <= i_cfg_data;
                    nos_pkg::CfgStartFirst:  y_first <= i_cfg_data;
                    nos_pkg::CfgStartSecond: y_second <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (seen == 0) begin
                    p = '0;
                    p.y = y_first;
                    p.last = i_in_last;
                end else if (seen == 1) begin
                    p = '0;
                    p.y = y_second;
                    p.last = i_in_last;
                end else begin
                    p = numerov_solve(i_in_data[31:0], i_in_data[63:32], i_in_last);
                end
                y_queue.push_back(p);
                if (i_in_last) begin
                    g_hist <= '{0, 0};
                    s_hist <= '{0, 0};
                    y_hist <= '{0, 0};
                    seen <= 0;
                end else begin
                    g_hist <= '{g_hist[1], i_in_data[31:0]};
                    s_hist <= '{s_hist[1], i_in_data[63:32]};
                    y_hist <= '{y_hist[1], p.y};
                    seen <= (seen < 2) ? seen + 1 : 2;
                end
            end
            if (i_out_valid && i_out_ready) begin
                p = {i_out_data, i_out_last, i_out_user[0], i_out_user[1]};
                if (y_queue.size() == 0) begin
                    if (o_errors < 10) $display("unexpected word y=%h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    e = y_queue.pop_front();
                    if (p !== e) begin
                        if (o_errors < 10)
                            $display("mismatch: exp y=%h l=%b s=%b z=%b got y=%h l=%b s=%b z=%b",
                                     e.y, e.last, e.sat, e.zdiv, p.y, p.last, p.sat, p.zdiv);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] in_data = '0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] out_data;
    logic        out_last;
    logic [1:0]  out_user;
    int          errors, pending;
    int          stall_mode = 0;

    always #2 clk = ~clk;

    numerov_ode_stepper_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
        .s_axis_tdata(in_data), .s_axis_tlast(in_last),
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
        .m_axis_tdata(out_data), .m_axis_tlast(out_last), .m_axis_tuser(out_user)
    );

    numerov_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_in_last(in_last),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_out_last(out_last), .i_out_user(out_user),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern: phases of always-ready, random, and mostly-stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(input logic [31:0] g, input logic [31:0] s, input logic last);
        logic rdy;
        in_valid <= 1'b1;
        in_data  <= {s, g};
        in_last  <= last;
        do begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value(input int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? 32'hffff_ffff : 0);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    initial begin
        int n, burst, sweep_len, k, phase;
        logic [31:0] h_set[6];
        h_set = '{32'h0, 32'hffff_ffff, 32'h0100_0000, 32'h0000_1000, 32'h1000_0000,
                  32'h0040_0000};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, then extremes
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'h0, 32'h0, 1'b1);
        drain();
        write_reg(nos_pkg::CfgStepSq, 32'hffff_ffff);
        write_reg(nos_pkg::CfgStartFirst, 32'h8000_0000);
        write_reg(nos_pkg::CfgStartSecond, 32'h7fff_ffff);
        // extremes with h = 2^32-1; zero divisor (12*2^44 + h*g = 0 with h = 2^28, g = -12*2^16) is in the next sweep
        send_point(32'h1, 32'h1, 1'b0);
        send_point(32'hffff_ffff, 32'hffff_ffff, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h0001_0000, 32'hffff_0000, 1'b1);
        drain();
        write_reg(nos_pkg::CfgStepSq, 32'h1000_0000);
        write_reg(nos_pkg::CfgStartFirst, 32'h0001_0000);
        write_reg(nos_pkg::CfgStartSecond, 32'h0000_8000);
        send_point(32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 1'b0);
        send_point(32'hfff4_0000, 32'h0001_0000, 1'b0);
        send_point(32'h0002_0000, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        drain();

        n = 0;
        phase = 0;
        while (n < 1600) begin
            write_reg(nos_pkg::CfgStepSq, (phase % 7 == 6) ? $urandom : h_set[phase % 6]);
            write_reg(nos_pkg::CfgStartFirst, pick_value($urandom_range(0, 3)));
            write_reg(nos_pkg::CfgStartSecond, pick_value($urandom_range(0, 3)));
            phase++;
            for (k = 0; k < 200 && n < 1600; ) begin
                burst = $urandom_range(1, 12);
                sweep_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                         : $urandom_range(4, 40);
                repeat (sweep_len) begin
                    sweep_len--;
                    send_point(pick_value($urandom_range(0, 3)),
                               pick_value($urandom_range(0, 3)), sweep_len == 0);
                    n++;
                    k++;
                    burst--;
                    if (burst == 0) begin
                        pause_sender();
                        burst = $urandom_range(1, 12);
                    end
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb failed");
        $finish;
    end
endmodule

[sim.f]
hw/rtl/nos_pkg.sv
hw/rtl/nos_divider.sv
hw/rtl/numerov_ode_stepper_unit.sv
sim/numerov_checker.sv
sim/tb.sv
